@@ rtl/miis_pkg.sv @@
package miis_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    // fixed field widths of the channels
    localparam int POINT_W  = 16;
    localparam int LENGTH_W = 7;
    localparam int POS_W    = 6;

    // control half of the link that one cell hands to the next
    typedef struct packed {
        logic valid;    // entry holds a chain end
        logic gt;       // entry is valid and its end exceeds the incoming end
    } t_link_ctl;

endpackage

@@ rtl/miis_if.sv @@
interface miis_req_if;
    logic                             valid;
    logic                             ready;
    logic                             first_item;
    logic [miis_pkg::POINT_W-1:0]     start_point;
    logic [miis_pkg::POINT_W-1:0]     end_point;

    modport source (output valid, first_item, start_point, end_point, input ready);
    modport sink   (input valid, first_item, start_point, end_point, output ready);
endinterface

interface miis_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [miis_pkg::LENGTH_W-1:0]    chain_length;
    logic                             wrote_entry;
    logic [miis_pkg::POS_W-1:0]       write_position;
    logic                             overflow;

    modport source (output valid, chain_length, wrote_entry, write_position, overflow,
                    input ready);
    modport sink   (input valid, chain_length, wrote_entry, write_position, overflow,
                    output ready);
endinterface

@@ rtl/max_increasing_interval_subseq.sv @@
// interval chain tracker
// i_req carries one interval per request (first_item, start_point, end_point);
// o_rsp returns one result per request (chain_length, wrote_entry,
// write_position, overflow), in request order.
// a row of TABLE_DEPTH cells holds the sorted chain end points, one per cell;
// every cell compares its end with the incoming interval in the same cycle and
// looks only at its left neighbor to decide whether it takes the new end.
// the result is registered and shows on o_rsp in the cycle after the request
// is taken. one request per cycle while the receiver takes results, set by that
// single parallel compare step across the cell row.
// i_req.ready stays high while the output register is empty or being drained,
// so a stalled receiver holds one result and blocks new requests until taken.
// reset (i_rst_n low, synchronous) empties the table and the output register;
// the cell contents are not cleared, entries past the chain length are unused.
// first_item set, or any request while the table is empty, restarts the table
// with that interval alone.
module max_increasing_interval_subseq #(
    parameter int TABLE_DEPTH = miis_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = miis_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    miis_req_if.sink   i_req,
    miis_rsp_if.source o_rsp
);
    import miis_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic                  w_accept;
    logic [COORD_BITS-1:0] w_start;
    logic [COORD_BITS-1:0] w_end;
    logic                  w_empty;
    logic                  w_full;

    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_we;
    logic [TABLE_DEPTH-1:0] w_append;
    t_link_ctl              w_link [TABLE_DEPTH+1];
    logic [COORD_BITS-1:0]  w_link_end [TABLE_DEPTH+1];

    logic                  w_wrote;
    logic                  w_any_append;
    logic                  w_ovf;
    logic [IDX_W-1:0]      w_pos;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [LENGTH_W-1:0]   r_chain;
    logic                  r_wrote;
    logic [POS_W-1:0]      r_pos;
    logic                  r_ovf;

    logic [CNT_W+LENGTH_W-1:0] w_count_ext;
    logic [IDX_W+POS_W-1:0]    w_pos_ext;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // coordinates are taken in their low COORD_BITS bits
    assign w_start = COORD_BITS'({{COORD_BITS{1'b0}}, i_req.start_point});
    assign w_end   = COORD_BITS'({{COORD_BITS{1'b0}}, i_req.end_point});

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(TABLE_DEPTH));

    assign w_link[0].valid = 1'b0;
    assign w_link[0].gt    = 1'b0;
    assign w_link_end[0]   = '0;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        assign w_valid[k] = (r_count > CNT_W'(k));

        miis_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_head     (k == 0),
            .i_valid    (w_valid[k]),
            .i_first    (i_req.first_item),
            .i_empty    (w_empty),
            .i_load     (w_accept),
            .i_start    (w_start),
            .i_end      (w_end),
            .i_prev     (w_link[k]),
            .i_prev_end (w_link_end[k]),
            .o_link     (w_link[k+1]),
            .o_end      (w_link_end[k+1]),
            .o_we       (w_we[k]),
            .o_append   (w_append[k])
        );
    end

    assign w_wrote      = |w_we;
    assign w_any_append = |w_append;

    // nothing greater and start beyond the last end, but no cell left
    assign w_ovf = !i_req.first_item && !w_empty && w_full && !w_link[TABLE_DEPTH].gt
                   && (w_start > w_link_end[TABLE_DEPTH]);

    always_comb begin
        w_pos = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_pos = w_pos | (w_we[k] ? IDX_W'(k) : '0);
        end
    end

    always_comb begin
        if (i_req.first_item || w_empty) begin
            n_count = CNT_W'(1);
        end else if (w_any_append) begin
            n_count = r_count + CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign w_count_ext = {{LENGTH_W{1'b0}}, n_count};
    assign w_pos_ext   = {{POS_W{1'b0}}, w_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chain <= w_count_ext[LENGTH_W-1:0];
            r_wrote <= w_wrote;
            r_pos   <= w_pos_ext[POS_W-1:0];
            r_ovf   <= w_ovf;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.chain_length   = r_chain;
    assign o_rsp.wrote_entry    = r_wrote;
    assign o_rsp.write_position = r_pos;
    assign o_rsp.overflow       = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_we))
        else $error("more than one cell takes the same interval");

    a_wrote_xor_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_wrote && r_ovf))
        else $error("overflow reported together with a write");

    a_first_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.first_item) |=> (r_count == CNT_W'(1)))
        else $error("first item did not restart the table");

    a_append_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_any_append && !i_req.first_item && !w_empty)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not grow the chain by one");

endmodule

@@ rtl/miis_cell.sv @@
module miis_cell #(
    parameter int COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_head,
    input  logic                     i_valid,
    input  logic                     i_first,
    input  logic                     i_empty,
    input  logic                     i_load,
    input  logic [COORD_BITS-1:0]    i_start,
    input  logic [COORD_BITS-1:0]    i_end,
    input  miis_pkg::t_link_ctl      i_prev,
    input  logic [COORD_BITS-1:0]    i_prev_end,
    output miis_pkg::t_link_ctl      o_link,
    output logic [COORD_BITS-1:0]    o_end,
    output logic                     o_we,
    output logic                     o_append
);
    import miis_pkg::*;

    logic [COORD_BITS-1:0] r_end;
    logic                  w_gt;
    logic                  w_found;
    logic                  w_append;
    logic                  w_pred_ok;

    assign w_gt      = i_valid && (r_end > i_end);
    // table is sorted, so the first greater entry is where the flag switches on
    assign w_found   = w_gt && !i_prev.gt;
    assign w_append  = !i_valid && i_prev.valid && !i_prev.gt;
    assign w_pred_ok = i_start > i_prev_end;

    always_comb begin
        if (i_head) begin
            o_we = i_first || i_empty || w_gt;
        end else begin
            o_we = !i_first && !i_empty && (w_found || w_append) && w_pred_ok;
        end
    end

    assign o_append = o_we && !i_valid;

    assign o_link.valid = i_valid;
    assign o_link.gt    = w_gt;
    assign o_end        = r_end;

    always_ff @(posedge i_clk) begin
        if (i_load && o_we) begin
            r_end <= i_end;
        end
    end

endmodule

@@ dv/tb_max_increasing_interval_subseq.sv @@
module tb_max_increasing_interval_subseq;

    import miis_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int N_ITEMS   = 1900;
    localparam int HOLD_LEN  = 120;

    typedef struct packed {
        logic [LENGTH_W-1:0] chain_length;
        logic                wrote_entry;
        logic [POS_W-1:0]    write_position;
        logic                overflow;
    } t_chain_result;

    // tracks the chain end table and the results the block owes us
    class t_chain_scoreboard;
        bit [POINT_W-1:0] chain_ends [DEPTH];
        int               chain_count;
        t_chain_result    owed_q [$];
        int               error_count;

        function new();
            chain_count = 0;
            error_count = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string msg);
            error_count++;
            if (error_count <= 30) $display("mismatch at %0t: %s", $time, msg);
        endtask

        function void note_request(bit restart, bit [POINT_W-1:0] s, bit [POINT_W-1:0] e);
            t_chain_result r;
            int idx;
            int k;
            r = '0;
            if (restart || chain_count == 0) begin
                chain_ends[0] = e;
                chain_count   = 1;
                r.wrote_entry = 1'b1;
            end else begin
                // first entry whose end exceeds the new end
                idx = chain_count;
                for (k = chain_count - 1; k >= 0; k--)
                    if (chain_ends[k] > e) idx = k;
                if (idx == 0) begin
                    chain_ends[0] = e;
                    r.wrote_entry = 1'b1;
                end else if (s > chain_ends[idx-1]) begin
                    if (idx == chain_count && chain_count >= DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        chain_ends[idx] = e;
                        if (idx == chain_count) chain_count++;
                        r.wrote_entry    = 1'b1;
                        r.write_position = idx[POS_W-1:0];
                    end
                end
            end
            r.chain_length = chain_count[LENGTH_W-1:0];
            owed_q = {owed_q, r};
        endfunction

        task check_result(t_chain_result got);
            t_chain_result want;
            if (owed_q.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = owed_q.pop_front();
            if (got.chain_length !== want.chain_length)
                report($sformatf("chain_length %0d, expected %0d",
                                 got.chain_length, want.chain_length));
            if (got.wrote_entry !== want.wrote_entry)
                report($sformatf("wrote_entry %b, expected %b",
                                 got.wrote_entry, want.wrote_entry));
            if (got.write_position !== want.write_position)
                report($sformatf("write_position %0d, expected %0d",
                                 got.write_position, want.write_position));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #4 i_clk = ~i_clk;

    miis_req_if req_if ();
    miis_rsp_if rsp_if ();

    max_increasing_interval_subseq u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_chain_scoreboard sb;
    int  n_sent;
    bit  src_burst;

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called right after an edge; returns at the edge where the request is taken
    task automatic send_interval(input bit restart, input int s, input int e);
        int gap;
        gap = pick_gap(src_burst);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.first_item  <= restart;
        req_if.start_point <= s[POINT_W-1:0];
        req_if.end_point   <= e[POINT_W-1:0];
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(restart, s[POINT_W-1:0], e[POINT_W-1:0]);
        n_sent++;
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    // increasing chain with random spacing; long runs push the table past full
    task automatic chain_run(input bit longrun);
        int len;
        int cursor;
        int s;
        int e;
        int i;
        len    = longrun ? $urandom_range(66, 90) : $urandom_range(8, 50);
        cursor = $urandom_range(0, 2000);
        for (i = 0; i < len; i++) begin
            if (!longrun && $urandom_range(0, 7) == 0) begin
                // lands among the stored ends: replacement or rejection
                s = $urandom_range(0, cursor);
                e = $urandom_range(0, cursor);
            end else begin
                s = cursor + $urandom_range(1, 40);
                e = s + $urandom_range(0, 60);
                cursor = e;
            end
            send_interval(i == 0 && (longrun || $urandom_range(0, 5) != 0), s, e);
        end
    endtask

    // small coordinates, lots of collisions with the table
    task automatic dense_run();
        int len;
        int s;
        int e;
        int i;
        len = $urandom_range(10, 60);
        for (i = 0; i < len; i++) begin
            s = $urandom_range(0, 127);
            e = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : s + $urandom_range(0, 20);
            send_interval(i == 0, s, e);
        end
    endtask

    task automatic noise_run();
        int len;
        int i;
        len = $urandom_range(5, 30);
        for (i = 0; i < len; i++)
            send_interval($urandom_range(0, 15) == 0, $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
    endtask

    initial begin : stimulus
        int run_no;
        int kind;
        sb     = new();
        n_sent = 0;
        src_burst = 1'b0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.first_item  <= 1'b0;
        req_if.start_point <= '0;
        req_if.end_point   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table without restart flag, then append, reject and replace
        send_interval(1'b0, 100, 200);
        send_interval(1'b0, 300, 400);
        send_interval(1'b0, 350, 500);      // start not past predecessor
        send_interval(1'b0, 150, 300);      // start not past predecessor
        send_interval(1'b0, 250, 300);      // replaces entry 1
        send_interval(1'b0, 50, 150);       // replaces entry 0
        send_interval(1'b0, 1000, 10);      // end below start
        send_interval(1'b0, 400, 350);      // end below start, mid table
        send_interval(1'b0, 65535, 0);
        send_interval(1'b1, 0, 0);
        send_interval(1'b0, 0, 0);
        send_interval(1'b0, 1, 65535);
        send_interval(1'b0, 65535, 65535);
        send_interval(1'b1, 65535, 65535);
        send_interval(1'b0, 0, 65535);
        send_interval(1'b1, 16'hAAAA, 16'h5555);
        send_interval(1'b0, 16'h5555, 16'hAAAA);
        send_interval(1'b0, 16'hAAAB, 16'hFFFE);
        send_interval(1'b1, 16'h5555, 16'hAAAA);
        send_interval(1'b0, 16'hAAAA, 16'hAAAA);
        wait_all_results();

        run_no = 0;
        while (n_sent < N_ITEMS) begin
            src_burst = ($urandom_range(0, 3) == 0);
            if (run_no % 8 == 7) wait_all_results();
            kind = $urandom_range(0, 9);
            if (run_no % 4 == 0) chain_run(1'b1);
            else if (kind < 6) chain_run(1'b0);
            else if (kind < 8) dense_run();
            else noise_run();
            run_no++;
        end

        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : result_side
        int stall_left;
        int cycle_cnt;
        bit rcv_burst;
        t_chain_result got;
        stall_left = 0;
        cycle_cnt  = 0;
        rcv_burst  = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.chain_length   = rsp_if.chain_length;
                got.wrote_entry    = rsp_if.wrote_entry;
                got.write_position = rsp_if.write_position;
                got.overflow       = rsp_if.overflow;
                sb.check_result(got);
            end
            cycle_cnt++;
            if (cycle_cnt % 256 == 0) rcv_burst = ($urandom_range(0, 2) == 0);
            // long hold-off so the block backs up into the request side
            if (cycle_cnt % 4000 == 500) stall_left = HOLD_LEN;
            else if (stall_left == 0) stall_left = pick_gap(rcv_burst);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #12000000;
        $display("simulation failed");
        $finish;
    end

endmodule
